// ----- rtl/tfn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths, stage counts and types of the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

	// vertex coordinate and normal formats
	localparam int COORD_BITS       = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int OUT_W            = 16;

	// edge, product and cross product widths
	localparam int E_W  = COORD_BITS + 1;
	localparam int P_W  = 2 * E_W;
	localparam int C_W  = P_W + 1;
	localparam int MG_W = P_W;

	// reduced magnitude, its square and the sum of squares
	localparam int M_W  = 31;
	localparam int SQ_W = 2 * M_W;
	localparam int S_W  = SQ_W + 2;

	// quotient m^2 * 2^(2F+2) / s and its integer square root
	localparam int DQ_W = 2 * NORMAL_FRAC_BITS + 3;
	localparam int R_W  = NORMAL_FRAC_BITS + 2;
	localparam int OP_W = 2 * R_W;
	localparam int Q_W  = NORMAL_FRAC_BITS + 1;

	// pipeline depth
	localparam int NPRE     = 6;
	localparam int NDIV     = DQ_W;
	localparam int NSQ      = R_W;
	localparam int NORM_STG = NDIV + NSQ;
	localparam int NSTG     = NPRE + NORM_STG + 1;

	// per item sideband carried past the normalizer
	typedef struct packed {
		logic [2:0]       neg;
		logic             deg;
		logic [OUT_W-1:0] face;
	} tfn_side_t;

endpackage

// ----- rtl/tfn_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_norm
// Pipelined restoring divider and digit-by-digit square root for three
// components: root = isqrt(floor(sq * 2^(2F+2) / s)), one bit per stage.
// ----------------------------------------------------------------------------
module tfn_norm
	import tfn_pkg::*;
(
	input  logic                clk,
	input  logic [NORM_STG-1:0] en,
	input  logic [S_W-1:0]      sum_sq,
	input  logic [SQ_W-1:0]     sq [3],
	output logic [R_W-1:0]      root [3]
);

	logic [S_W-1:0]  sum_s [NDIV];
	logic [S_W-1:0]  rem_s [NDIV][3];
	logic [DQ_W-1:0] quo_s [NDIV][3];
	logic [OP_W-1:0] op_s  [NSQ][3];
	logic [OP_W-1:0] res_s [NSQ][3];

	// divider stages, one quotient bit each
	for (genvar j = 0; j < NDIV; j++) begin : g_div
		localparam int PREV = (j == 0) ? 0 : j - 1;
		logic [S_W-1:0]  rem_n [3];
		logic [DQ_W-1:0] quo_n [3];
		logic [S_W-1:0]  sum_in;

		always_comb begin
			logic [S_W:0]    trial;
			logic [S_W-1:0]  rem_in;
			logic [DQ_W-1:0] quo_in;
			logic            bit_in;
			for (int c = 0; c < 3; c++) begin
				if (j == 0) begin
					rem_in = S_W'(sq[c] >> 1);
					bit_in = sq[c][0];
					quo_in = '0;
				end else begin
					rem_in = rem_s[PREV][c];
					bit_in = 1'b0;
					quo_in = quo_s[PREV][c];
				end
				trial = {rem_in, bit_in};
				if (trial >= {1'b0, sum_in}) begin
					rem_n[c] = S_W'(trial - {1'b0, sum_in});
					quo_n[c] = {quo_in[DQ_W-2:0], 1'b1};
				end else begin
					rem_n[c] = trial[S_W-1:0];
					quo_n[c] = {quo_in[DQ_W-2:0], 1'b0};
				end
			end
		end

		if (j == 0) begin : g_first
			assign sum_in = sum_sq;
		end else begin : g_next
			assign sum_in = sum_s[PREV];
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				sum_s[j] <= sum_in;
				for (int c = 0; c < 3; c++) begin
					rem_s[j][c] <= rem_n[c];
					quo_s[j][c] <= quo_n[c];
				end
			end
		end
	end

	// square root stages, one root bit each
	for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
		localparam int PREV = (j == 0) ? 0 : j - 1;
		localparam logic [OP_W-1:0] ONE = OP_W'(1) << (2 * (NSQ - 1 - j));
		logic [OP_W-1:0] op_n  [3];
		logic [OP_W-1:0] res_n [3];

		always_comb begin
			logic [OP_W-1:0] op_in;
			logic [OP_W-1:0] res_in;
			logic [OP_W:0]   t;
			for (int c = 0; c < 3; c++) begin
				if (j == 0) begin
					op_in  = OP_W'(quo_s[NDIV-1][c]);
					res_in = '0;
				end else begin
					op_in  = op_s[PREV][c];
					res_in = res_s[PREV][c];
				end
				t = {1'b0, res_in} + {1'b0, ONE};
				if ({1'b0, op_in} >= t) begin
					op_n[c]  = OP_W'({1'b0, op_in} - t);
					res_n[c] = (res_in >> 1) + ONE;
				end else begin
					op_n[c]  = op_in;
					res_n[c] = res_in >> 1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[NDIV+j]) begin
				for (int c = 0; c < 3; c++) begin
					op_s[j][c]  <= op_n[c];
					res_s[j][c] <= res_n[c];
				end
			end
		end
	end

	// final root per component
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			root[c] = res_s[NSQ-1][c][R_W-1:0];
		end
	end

endmodule

// ----- rtl/triangle_face_normal.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal
// Flat unit normal of a triangle from three Q8.8 vertices, in Q1.14.
// ----------------------------------------------------------------------------
// One triangle enters per clock unless back-pressure stalls the input, and
// its normal passes through edge, cross product and sum-of-squares
// arithmetic, restoring division one quotient bit per stage, square root one
// root bit per stage and 1 output register. Every stage holds its own valid
// bit and moves whenever the next stage is empty or moving, so bubbles
// collapse under back-pressure. A zero cross product yields a zero vector
// with degenerate set. While enable is 0 input beats are taken and dropped.
module triangle_face_normal
	import tfn_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic                    cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [15:0]      a_x,
	input  logic signed [15:0]      a_y,
	input  logic signed [15:0]      a_z,
	input  logic signed [15:0]      b_x,
	input  logic signed [15:0]      b_y,
	input  logic signed [15:0]      b_z,
	input  logic signed [15:0]      c_x,
	input  logic signed [15:0]      c_y,
	input  logic signed [15:0]      c_z,
	input  logic [15:0]             face_tag,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] normal_x,
	output logic signed [OUT_W-1:0] normal_y,
	output logic signed [OUT_W-1:0] normal_z,
	output logic                    degenerate,
	output logic [OUT_W-1:0]        face_out
);

	logic            enable_q;
	logic [NSTG:1]   v_q;
	logic [NSTG:1]   adv;

	// enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			enable_q <= cfg_wr_data;
		end
	end

	// stage advance chain
	always_comb begin
		adv[NSTG] = ~v_q[NSTG] | out_ready;
		for (int i = NSTG - 1; i >= 1; i--) begin
			adv[i] = ~v_q[i] | adv[i+1];
		end
	end

	assign in_ready = adv[1];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[1]) begin
				v_q[1] <= in_valid & enable_q;
			end
			for (int i = 2; i <= NSTG; i++) begin
				if (adv[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	// stage 1: edges
	logic signed [E_W-1:0] e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic [OUT_W-1:0]      face_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			e1x_s1  <= E_W'(a_x) - E_W'(b_x);
			e1y_s1  <= E_W'(a_y) - E_W'(b_y);
			e1z_s1  <= E_W'(a_z) - E_W'(b_z);
			e2x_s1  <= E_W'(c_x) - E_W'(b_x);
			e2y_s1  <= E_W'(c_y) - E_W'(b_y);
			e2z_s1  <= E_W'(c_z) - E_W'(b_z);
			face_s1 <= face_tag;
		end
	end

	// stage 2: six partial products
	logic signed [P_W-1:0] pyz_s2, pzy_s2, pzx_s2, pxz_s2, pxy_s2, pyx_s2;
	logic [OUT_W-1:0]      face_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			pyz_s2  <= e2y_s1 * e1z_s1;
			pzy_s2  <= e2z_s1 * e1y_s1;
			pzx_s2  <= e2z_s1 * e1x_s1;
			pxz_s2  <= e2x_s1 * e1z_s1;
			pxy_s2  <= e2x_s1 * e1y_s1;
			pyx_s2  <= e2y_s1 * e1x_s1;
			face_s2 <= face_s1;
		end
	end

	// stage 3: cross product
	logic signed [C_W-1:0] n_s3 [3];
	logic [OUT_W-1:0]      face_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			n_s3[0] <= C_W'(pyz_s2) - C_W'(pzy_s2);
			n_s3[1] <= C_W'(pzx_s2) - C_W'(pxz_s2);
			n_s3[2] <= C_W'(pxy_s2) - C_W'(pyx_s2);
			face_s3 <= face_s2;
		end
	end

	// stage 4: sign, magnitude and common range reduction
	logic [M_W-1:0]   m_s4 [3];
	logic [2:0]       neg_s4;
	logic             deg_s4;
	logic [OUT_W-1:0] face_s4;
	logic [MG_W-1:0]  mag [3];
	logic [MG_W-1:0]  mag_or;
	logic [1:0]       shamt;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mag[c] = n_s3[c][C_W-1] ? MG_W'(-n_s3[c]) : MG_W'(n_s3[c]);
		end
		mag_or = mag[0] | mag[1] | mag[2];
		if (mag_or[MG_W-1]) begin
			shamt = 2'd3;
		end else if (mag_or[MG_W-2]) begin
			shamt = 2'd2;
		end else if (mag_or[MG_W-3]) begin
			shamt = 2'd1;
		end else begin
			shamt = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int c = 0; c < 3; c++) begin
				m_s4[c]   <= M_W'(mag[c] >> shamt);
				neg_s4[c] <= n_s3[c][C_W-1];
			end
			deg_s4  <= (mag_or == '0);
			face_s4 <= face_s3;
		end
	end

	// stage 5: squares
	logic [SQ_W-1:0]  sq_s5 [3];
	tfn_side_t        side_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int c = 0; c < 3; c++) begin
				sq_s5[c] <= m_s4[c] * m_s4[c];
			end
			side_s5 <= '{neg: neg_s4, deg: deg_s4, face: face_s4};
		end
	end

	// stage 6: sum of squares
	logic [SQ_W-1:0] sq_s6 [3];
	logic [S_W-1:0]  sum_s6;
	tfn_side_t       side_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			sq_s6   <= sq_s5;
			sum_s6  <= S_W'(sq_s5[0]) + S_W'(sq_s5[1]) + S_W'(sq_s5[2]);
			side_s6 <= side_s5;
		end
	end

	// divide and square root
	logic [R_W-1:0] root [3];

	tfn_norm u_norm (
		.clk    (clk),
		.en     (adv[NPRE+NORM_STG:NPRE+1]),
		.sum_sq (sum_s6),
		.sq     (sq_s6),
		.root   (root)
	);

	// sideband alongside the normalizer
	tfn_side_t side_s [NORM_STG];

	always_ff @(posedge clk) begin
		for (int j = 0; j < NORM_STG; j++) begin
			if (adv[NPRE+1+j]) begin
				side_s[j] <= (j == 0) ? side_s6 : side_s[(j == 0) ? 0 : j - 1];
			end
		end
	end

	// output stage: round to nearest and apply sign
	logic signed [OUT_W-1:0] nrm_q [3];
	logic                    deg_q;
	logic [OUT_W-1:0]        face_q;
	logic [Q_W-1:0]          qmag [3];
	tfn_side_t               side_last;

	assign side_last = side_s[NORM_STG-1];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qmag[c] = Q_W'(({1'b0, root[c]} + (R_W + 1)'(1)) >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NSTG]) begin
			for (int c = 0; c < 3; c++) begin
				if (side_last.deg) begin
					nrm_q[c] <= '0;
				end else if (side_last.neg[c]) begin
					nrm_q[c] <= -OUT_W'(qmag[c]);
				end else begin
					nrm_q[c] <= OUT_W'(qmag[c]);
				end
			end
			deg_q  <= side_last.deg;
			face_q <= side_last.face;
		end
	end

	assign out_valid  = v_q[NSTG];
	assign normal_x   = nrm_q[0];
	assign normal_y   = nrm_q[1];
	assign normal_z   = nrm_q[2];
	assign degenerate = deg_q;
	assign face_out   = face_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
// Triangles are queued by the stimulus process. A bursty driver feeds them
// to the block. Each triangle accepted while enabled is run through a local
// fixed point normal calculation, and its expected normal is queued. A
// monitor with a random stall pattern takes the result beats and compares
// them field by field with the oldest expected normal. The enable register
// is switched between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench
	import tfn_pkg::*;
();

	typedef struct packed {
		logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
		logic [15:0]        tag;
	} tri_t;

	typedef struct packed {
		logic signed [15:0] nx, ny, nz;
		logic               deg;
		logic [15:0]        face;
	} nrm_t;

	localparam int DRAIN_CYCLES = NSTG + 30;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	tri_t cur = '0;
	nrm_t got;

	tri_t tri_q[$];
	nrm_t normal_q[$];
	logic enable_mdl = 1'b1;
	int   errors = 0;
	int   results_seen = 0;
	int   cycles = 0;

	always #5 clk = ~clk;

	triangle_face_normal dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_x(cur.ax), .a_y(cur.ay), .a_z(cur.az),
		.b_x(cur.bx), .b_y(cur.by), .b_z(cur.bz),
		.c_x(cur.cx), .c_y(cur.cy), .c_z(cur.cz),
		.face_tag(cur.tag),
		.out_valid(out_valid), .out_ready(out_ready),
		.normal_x(got.nx), .normal_y(got.ny), .normal_z(got.nz),
		.degenerate(got.deg), .face_out(got.face)
	);

	// expected unit normal of e2 x e1, rounded to nearest in Q1.14
	function automatic nrm_t face_normal(tri_t t);
		longint e1x, e1y, e1z, e2x, e2y, e2z;
		longint cr[3];
		logic [63:0] mag[3];
		logic [2:0] neg;
		logic [63:0] sum;
		logic [127:0] lim, d;
		logic [15:0] lo, hi, mid;
		logic [15:0] q[3];
		nrm_t r;
		e1x = longint'(t.ax) - longint'(t.bx);
		e1y = longint'(t.ay) - longint'(t.by);
		e1z = longint'(t.az) - longint'(t.bz);
		e2x = longint'(t.cx) - longint'(t.bx);
		e2y = longint'(t.cy) - longint'(t.by);
		e2z = longint'(t.cz) - longint'(t.bz);
		cr[0] = e2y * e1z - e2z * e1y;
		cr[1] = e2z * e1x - e2x * e1z;
		cr[2] = e2x * e1y - e2y * e1x;
		for (int i = 0; i < 3; i++) begin
			neg[i] = cr[i] < 0;
			mag[i] = neg[i] ? -cr[i] : cr[i];
		end
		// wide cross product: shift all together until below 2^31
		while ((mag[0] | mag[1] | mag[2]) >= 64'h8000_0000)
			for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
		sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		r.face = t.tag;
		r.deg = (sum == 0);
		for (int i = 0; i < 3; i++) begin
			lo = 0;
			hi = 16'd1 << NORMAL_FRAC_BITS;
			lim = {64'd0, mag[i] * mag[i]} << (2 * NORMAL_FRAC_BITS + 2);
			// largest q with (2q-1)^2 * s <= m^2 * 2^(2F+2)
			while (!r.deg && lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				d = 2 * mid - 1;
				if (d * d * {64'd0, sum} <= lim) lo = mid;
				else hi = mid - 1;
			end
			q[i] = neg[i] ? -lo : lo;
		end
		r.nx = q[0];
		r.ny = q[1];
		r.nz = q[2];
		return r;
	endfunction

	function automatic logic signed [15:0] pick_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return $signed(16'($urandom_range(0, 1024))) - 16'sd512;
			default: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return 16'sd0;
					default: return 16'($urandom);
				endcase
			end
		endcase
	endfunction

	function automatic tri_t rand_tri();
		tri_t t;
		int mode;
		int k;
		mode = $urandom_range(0, 9);
		t.ax = pick_coord(mode <= 3 ? 0 : (mode <= 7 ? 1 : 2));
		t.ay = pick_coord(mode <= 3 ? 0 : (mode <= 7 ? 1 : 2));
		t.az = pick_coord(mode <= 3 ? 0 : (mode <= 7 ? 1 : 2));
		t.bx = pick_coord(mode <= 3 ? 0 : (mode <= 7 ? 1 : 2));
		t.by = pick_coord(mode <= 3 ? 0 : (mode <= 7 ? 1 : 2));
		t.bz = pick_coord(mode <= 3 ? 0 : (mode <= 7 ? 1 : 2));
		t.cx = pick_coord(mode <= 3 ? 0 : (mode <= 7 ? 1 : 2));
		t.cy = pick_coord(mode <= 3 ? 0 : (mode <= 7 ? 1 : 2));
		t.cz = pick_coord(mode <= 3 ? 0 : (mode <= 7 ? 1 : 2));
		// collinear or repeated vertex gives a zero cross product
		if (mode == 6) begin
			k = $urandom_range(0, 6) - 3;
			t.cx = 16'(t.bx + k * (t.ax - t.bx));
			t.cy = 16'(t.by + k * (t.ay - t.by));
			t.cz = 16'(t.bz + k * (t.az - t.bz));
		end else if (mode == 7) begin
			t.cx = t.ax; t.cy = t.ay; t.cz = t.az;
		end
		t.tag = 16'($urandom);
		return t;
	endfunction

	function automatic tri_t mk(int ax, int ay, int az, int bx, int by, int bz,
			int cx, int cy, int cz, int tag);
		tri_t t;
		t.ax = 16'(ax); t.ay = 16'(ay); t.az = 16'(az);
		t.bx = 16'(bx); t.by = 16'(by); t.bz = 16'(bz);
		t.cx = 16'(cx); t.cy = 16'(cy); t.cz = 16'(cz);
		t.tag = 16'(tag);
		return t;
	endfunction

	// driver: bursts of beats with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (enable_mdl) normal_q.push_back(face_normal(tri_q[0]));
			void'(tri_q.pop_front());
		end
		if (in_valid && !in_ready) begin
			// hold the beat until accepted
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else if (tri_q.size() > 0 && arst_n) begin
			in_valid <= 1'b1;
			cur <= tri_q[0];
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 40);
				gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	// monitor: compare result beats, stall on its own pattern
	int hold_left = 0;
	logic held_once = 1'b0;
	int stall_mode = 0;
	nrm_t exp_n;
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (normal_q.size() == 0) begin
				errors <= errors + 1;
				$display("%0t: unexpected normal beat face %0d", $time, got.face);
			end else begin
				exp_n = normal_q.pop_front();
				if (got !== exp_n) begin
					errors <= errors + 1;
					$display("%0t: mismatch exp n=(%0d,%0d,%0d) deg=%0b face=%0d",
						$time, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.deg, exp_n.face);
					$display("%0t:          got n=(%0d,%0d,%0d) deg=%0b face=%0d",
						$time, got.nx, got.ny, got.nz, got.deg, got.face);
				end
			end
		end
		// long hold-off once, so the pipeline fills and stalls its input
		if (!held_once && results_seen == 300) begin
			held_once <= 1'b1;
			hold_left <= 400;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= (hold_left == 1);
		end else begin
			if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ($urandom_range(0, 2) == 0);
			endcase
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic wait_idle();
		do @(posedge clk);
		while (tri_q.size() != 0 || in_valid || normal_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_enable(logic v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		enable_mdl = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) tri_q.push_back(rand_tri());
	endtask

	// stimulus phases
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes, axis planes, degenerate shapes, wide products
		tri_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		tri_q.push_back(mk(256, 0, 0, 0, 0, 0, 0, 256, 0, 65535));
		tri_q.push_back(mk(0, 256, 0, 0, 0, 0, 256, 0, 0, 1));
		tri_q.push_back(mk(0, 0, 256, 0, 0, 0, 256, 0, 0, 2));
		tri_q.push_back(mk(256, 0, 0, 0, 0, 0, 0, 0, 256, 3));
		tri_q.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1, 0, 4));
		tri_q.push_back(mk(32767, 0, 0, -32768, 0, 0, -32768, 32767, 0, 5));
		tri_q.push_back(mk(32767, -32768, 32767, -32768, 32767, -32768,
			32767, 32767, -32768, 6));
		tri_q.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
			-32768, 32767, -32768, 7));
		tri_q.push_back(mk(32767, 32767, 32767, -32768, -32768, -32768,
			0, 0, 0, 8));
		tri_q.push_back(mk(10, 20, 30, 10, 20, 30, 5, 6, 7, 9));
		tri_q.push_back(mk(1, 2, 3, 2, 4, 6, 3, 6, 9, 10));
		tri_q.push_back(mk(1, 1, 0, 0, 0, 0, 1, 0, 0, 11));
		tri_q.push_back(mk(3, 4, 0, 0, 0, 0, 0, 0, 5, 12));
		tri_q.push_back(mk(1, 0, 0, 0, 0, 0, 0, 1, 1, 13));
		tri_q.push_back(mk(-1, -1, -1, 0, 0, 0, 1, -1, 0, 14));
		tri_q.push_back(mk(-32768, 0, 0, 32767, 0, 0, 32767, 0, -32768, 15));
		tri_q.push_back(mk(100, -7, 33, -5, 2, 9, 40, 50, -60, 32768));
		wait_idle();
		write_enable(1'b0);
		queue_random(40);
		wait_idle();
		write_enable(1'b1);
		queue_random(700);
		wait_idle();
		write_enable(1'b0);
		queue_random(30);
		wait_idle();
		write_enable(1'b1);
		queue_random(800);
		wait_idle();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
